>>> src/sha256_pkg.sv
// SHA-256 hasher package: round constants, initial hash values, state enum.
// Used by the hasher top level and its round core.
`default_nettype none
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } state_t;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam int unsigned LEN_POS  = 56;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

>>> src/sha256_round.sv
// SHA-256 round core: working variables a..h, one round per cycle while step is high.
// Uses sha256_pkg for constants and rotate helper.
`default_nettype none
module sha256_round (
    input  wire logic        aclk,
    input  wire logic        load,        // load working vars from chain
    input  wire logic [255:0] chain_in,   // h0 in [255:224]
    input  wire logic        step,
    input  wire logic [5:0]  round_idx,
    input  wire logic [31:0] w_in,
    output logic [255:0]     vars_out     // a in [255:224]
);
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0] t1, t2;

    // round function
    always_comb begin
        t1 = h_reg + (sha256_pkg::ror(e_reg, 6) ^ sha256_pkg::ror(e_reg, 11)
             ^ sha256_pkg::ror(e_reg, 25)) + ((e_reg & f_reg) ^ (~e_reg & g_reg))
             + sha256_pkg::round_k(round_idx) + w_in;
        t2 = (sha256_pkg::ror(a_reg, 2) ^ sha256_pkg::ror(a_reg, 13)
             ^ sha256_pkg::ror(a_reg, 22))
             + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            {a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg} <= chain_in;
        end else if (step) begin
            h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg;
            e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg;
            a_reg <= t1 + t2;
        end
    end

    assign vars_out = {a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg};
endmodule
`default_nettype wire

>>> src/sha256_message_hasher.sv
// SHA-256 hasher top level: byte packing, block memory, padding, digest output.
// Depends on sha256_pkg and sha256_round.
//
// Takes one message byte per request and emits the eight 32-bit digest words
// after a request marked last. Bytes are packed big-endian into a 16-word block
// memory; the rolling message schedule lives in a 16-word register window fed
// by that memory. The 64th byte of a block starts compression: a load state that
// primes the memory read, 64 rounds at one round per cycle (with one schedule
// word per cycle from memory for rounds 0..15 and from the window after), and
// an add state. A last request first writes the padded tail block word by word,
// then compresses it; a tail of 56 or more bytes needs a second padded block,
// and a last byte that fills a block costs one data compression plus one padded
// block. The digest is then shown for eight result requests, one per cycle when
// not stalled. No clearing pass is needed.
`default_nettype none
module sha256_message_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [8] byte_valid, rest 0
    input  wire logic        s_tlast,   // is_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] digest_word
    output logic [2:0]       m_tuser,   // [2:0] word_index
    output logic             m_tlast    // last_word
);
    sha256_pkg::state_t state_reg, state_next;

    // block memory: 16 words of the current block
    logic [31:0] wmem [16];
    logic [31:0] rd_reg;
    logic [3:0]  rd_addr;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;

    // chain value (8 words; read by index for the digest output)
    logic [31:0] chain_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [31:0] word_reg;           // partial word being packed
    logic [6:0]  cnt_reg;            // round counter
    logic        final_reg;          // writing/compressing the second padded block
    logic        two_reg;            // pad needs an extra block
    logic [63:0] total_reg;
    logic [2:0]  oidx_reg;
    logic [3:0]  pad_reg;            // padding word index
    logic [31:0] w_hist [16];        // window of schedule words for round core
    logic [255:0] chain_pk, vars;
    logic        rc_load, rc_step;
    logic [31:0] w_cur;

    logic in_acc;
    assign in_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == sha256_pkg::ST_IDLE);

    // schedule expansion from the window: w[r] = s1(w[r-2]) + w[r-7] + s0(w[r-15]) + w[r-16]
    logic [31:0] w2, w15, s0, s1, w_new;
    always_comb begin
        w2  = w_hist[1];
        w15 = w_hist[14];
        s1 = sha256_pkg::ror(w2, 17) ^ sha256_pkg::ror(w2, 19) ^ (w2 >> 10);
        s0 = sha256_pkg::ror(w15, 7) ^ sha256_pkg::ror(w15, 18) ^ (w15 >> 3);
        w_new = s1 + w_hist[6] + s0 + w_hist[15];
    end

    // round index and word fed to the core: during rounds 0..15 from memory
    logic [5:0] ridx;
    assign ridx = cnt_reg[5:0];
    assign w_cur = (cnt_reg < 7'd16) ? rd_reg : w_new;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            chain_pk[255 - 32*i -: 32] = chain_reg[i];
        end
    end

    sha256_round u_round (
        .aclk      (aclk),
        .load      (rc_load),
        .chain_in  (chain_pk),
        .step      (rc_step),
        .round_idx (ridx),
        .w_in      (w_cur),
        .vars_out  (vars)
    );

    // pad word content for word pad_reg of the tail block
    logic [31:0] pad_word;
    logic [3:0]  fw;
    assign fw = fill_reg[5:2];
    always_comb begin
        pad_word = 32'h0;
        if (!two_reg || final_reg) begin
            if (pad_reg == 4'd14) pad_word = total_reg[63:32];
            if (pad_reg == 4'd15) pad_word = total_reg[31:0];
        end
        if (!final_reg && pad_reg == fw) begin
            // word holding pending bytes plus the 0x80 marker
            case (fill_reg[1:0])
                2'd0: pad_word = {sha256_pkg::PAD_BYTE, 24'h0};
                2'd1: pad_word = {word_reg[7:0], sha256_pkg::PAD_BYTE, 16'h0};
                2'd2: pad_word = {word_reg[15:0], sha256_pkg::PAD_BYTE, 8'h0};
                2'd3: pad_word = {word_reg[23:0], sha256_pkg::PAD_BYTE};
                default: pad_word = 32'h0;
            endcase
        end
    end

    // control
    logic last_pend_reg;
    logic full_last_reg;             // last byte filled a block, pad block follows
    always_comb begin
        state_next = state_reg;
        rc_load = 1'b0;
        rc_step = 1'b0;
        wr_en = 1'b0;
        wr_addr = fill_reg[5:2];
        wr_data = {word_reg[23:0], s_tdata[7:0]};
        rd_addr = cnt_reg[3:0];
        m_tvalid = 1'b0;
        case (state_reg)
            sha256_pkg::ST_IDLE: begin
                if (in_acc && s_tdata[8] && fill_reg[1:0] == 2'd3) begin
                    wr_en = 1'b1;
                end
                if (in_acc && s_tdata[8] && fill_reg == 6'd63) begin
                    state_next = sha256_pkg::ST_LOAD;
                end else if (in_acc && s_tlast) begin
                    state_next = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_PAD: begin
                wr_en = (pad_reg >= fw) || final_reg;
                wr_addr = pad_reg;
                wr_data = pad_word;
                if (pad_reg == 4'd15) state_next = sha256_pkg::ST_LOAD;
            end
            sha256_pkg::ST_LOAD: begin
                // prime the memory read for word 0
                rc_load = 1'b1;
                rd_addr = 4'd0;
                state_next = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_ROUND: begin
                rc_step = 1'b1;
                rd_addr = cnt_reg[3:0] + 4'd1;
                if (cnt_reg == 7'd63) state_next = sha256_pkg::ST_ADD;
            end
            sha256_pkg::ST_ADD: begin
                if (full_last_reg)
                    state_next = sha256_pkg::ST_PAD;
                else if (last_pend_reg && two_reg && !final_reg)
                    state_next = sha256_pkg::ST_PAD;
                else if (last_pend_reg)
                    state_next = sha256_pkg::ST_OUT;
                else
                    state_next = sha256_pkg::ST_IDLE;
            end
            sha256_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready && oidx_reg == 3'd7) state_next = sha256_pkg::ST_IDLE;
            end
            default: state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    // block memory, synchronous read
    always_ff @(posedge aclk) begin
        if (wr_en) wmem[wr_addr] <= wr_data;
        rd_reg <= wmem[rd_addr];
    end

    // schedule window shift during rounds
    always_ff @(posedge aclk) begin
        if (rc_step) begin
            w_hist[0] <= w_cur;
            for (int i = 1; i < 16; i++) w_hist[i] <= w_hist[i-1];
        end
    end

    // datapath and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha256_pkg::ST_IDLE;
            fill_reg <= 6'd0;
            bits_reg <= 64'd0;
            cnt_reg <= 7'd0;
            final_reg <= 1'b0;
            two_reg <= 1'b0;
            last_pend_reg <= 1'b0;
            full_last_reg <= 1'b0;
            oidx_reg <= 3'd0;
            pad_reg <= 4'd0;
            for (int i = 0; i < 8; i++) chain_reg[i] <= sha256_pkg::init_h(3'(i));
        end else begin
            state_reg <= state_next;
            case (state_reg)
                sha256_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        if (s_tdata[8]) begin
                            word_reg <= {word_reg[23:0], s_tdata[7:0]};
                            fill_reg <= fill_reg + 6'd1;
                        end
                        last_pend_reg <= s_tlast;
                        full_last_reg <= s_tlast && s_tdata[8] && (fill_reg == 6'd63);
                        final_reg <= 1'b0;
                        pad_reg <= 4'd0;
                        cnt_reg <= 7'd0;
                        if (s_tlast) begin
                            // pending count after this byte
                            if (s_tdata[8] && fill_reg == 6'd63) begin
                                two_reg <= 1'b0;
                                total_reg <= bits_reg + 64'd512;
                            end else begin
                                two_reg <= (fill_reg + {5'd0, s_tdata[8]})
                                           >= 6'(sha256_pkg::LEN_POS);
                                total_reg <= bits_reg
                                    + {55'd0, fill_reg + {5'd0, s_tdata[8]}, 3'd0};
                            end
                        end
                    end
                end
                sha256_pkg::ST_PAD: begin
                    pad_reg <= pad_reg + 4'd1;
                    cnt_reg <= 7'd0;
                end
                sha256_pkg::ST_ROUND: begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
                sha256_pkg::ST_ADD: begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + vars[255 - 32*i -: 32];
                    if (!last_pend_reg) begin
                        bits_reg <= bits_reg + 64'd512;
                    end else if (full_last_reg) begin
                        // data block done, the padding block comes next
                        pad_reg <= 4'd0;
                    end else if (two_reg && !final_reg) begin
                        final_reg <= 1'b1;
                        pad_reg <= 4'd0;
                    end else begin
                        oidx_reg <= 3'd0;
                    end
                    full_last_reg <= 1'b0;
                    fill_reg <= 6'd0;
                end
                sha256_pkg::ST_OUT: begin
                    if (m_tready) begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= sha256_pkg::init_h(3'(i));
                            bits_reg <= 64'd0;
                            fill_reg <= 6'd0;
                            last_pend_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tdata = chain_reg[oidx_reg];
    assign m_tuser = oidx_reg;
    assign m_tlast = (oidx_reg == 3'd7);
endmodule
`default_nettype wire

>>> src/sha256_checker.sv
// Port-level checker for the SHA-256 hasher, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module sha256_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);
    // no input taken while digest words are offered
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input ready during output");
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");
    // tlast marks word seven
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7))) else $error("tlast mismatch");
    // words advance in order
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == $past(m_tuser) + 3'd1)
        else $error("word order");
endmodule

bind sha256_message_hasher sha256_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire
